@@ rtl/tdvt_pkg.sv @@
package tdvt_pkg;

  localparam int ROWS     = 64;
  localparam int COLS     = 32;
  localparam int VERG     = 4;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COL_W    = $clog2(COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = 2 ** ADDR_W;
  localparam int VAL_W    = 32;
  localparam int LINE_W   = VAL_W * VERG;
  localparam int SUM_W    = VAL_W + $clog2(VERG) + 1;

  localparam logic [VAL_W-1:0] INIT_VALUE = 32'd6553600;

  typedef logic [LINE_W-1:0] line_t;

  typedef enum logic [1:0] {
    CFG_BASE_ROW,
    CFG_EXPLORE_PROB,
    CFG_LEARN_RATE,
    CFG_DISCOUNT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_UPDATE,
    OP_SET,
    OP_NONE
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_D_RS,
    S_D_RU,
    S_D_RD,
    S_D_T1,
    S_D_CS,
    S_D_CU,
    S_D_CD,
    S_D_T2,
    S_U_RC,
    S_U_RN,
    S_U_M1,
    S_U_M2,
    S_U_M3,
    S_U_WB
  } state_e;

  function automatic logic signed [VAL_W-1:0] lane_get(line_t line, logic [1:0] v);
    lane_get = $signed(line[32'(v) * VAL_W +: VAL_W]);
  endfunction

  function automatic line_t lane_set(line_t line, logic [1:0] v, logic [VAL_W-1:0] val);
    line_t l;
    l = line;
    l[32'(v) * VAL_W +: VAL_W] = val;
    lane_set = l;
  endfunction

  function automatic logic signed [SUM_W-1:0] line_sum(line_t line);
    logic signed [SUM_W-1:0] s;
    s = '0;
    for (int k = 0; k < VERG; k++) begin
      s = s + SUM_W'($signed(line[k * VAL_W +: VAL_W]));
    end
    line_sum = s;
  endfunction

endpackage

@@ rtl/td_value_table_greedy_agent_top.sv @@
// TD(0) value-table agent with epsilon-greedy draw. The table sits in one
// single-port-read RAM, one line per (row, column) holding all vergence
// values. After reset a clearing pass writes 100.0 to every line, one line
// per cycle; no item is accepted until it ends, config writes are taken as
// ever. One item is in flight at a time: set, unused op and an exploring
// draw load the result register from the dispatch state, an update after
// two table reads and two registered multiplies, a greedy draw after six
// table reads through the one read port and two compare steps. The next item
// is accepted while a result still waits in the output register.
module td_value_table_greedy_agent_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          thres1_i,
  input  logic [7:0]          thres2_i,
  input  logic [1:0]          vergence_i,
  input  logic signed [31:0]  reward_i,
  input  logic [15:0]         rand_explore_i,
  input  logic [5:0]          rand_row_i,
  input  logic [4:0]          rand_col_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_thres1_o,
  output logic [7:0]          out_thres2_o,
  output logic [1:0]          out_vergence_o,
  output logic                explored_o,
  output logic signed [31:0]  value_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i
);

  tdvt_pkg::state_e state_q, state_d;

  logic [7:0]  base_row_q;
  logic [16:0] explore_prob_q;
  logic [15:0] learn_rate_q;
  logic [15:0] discount_q;

  tdvt_pkg::op_e      op_q;
  logic [7:0]         t1_in_q, t2_in_q;
  logic [1:0]         verg_in_q;
  logic signed [31:0] reward_q;
  logic [15:0]        rexp_q;
  logic [5:0]         rrow_q;
  logic [4:0]         rcol_q;

  logic [7:0] cur_t1_q, cur_t2_q;
  logic [1:0] cur_verg_q;
  logic       explore_q;

  logic [tdvt_pkg::ADDR_W-1:0] clear_cnt_q;
  logic [tdvt_pkg::ROW_W-1:0]  row_i_q;
  logic signed [tdvt_pkg::SUM_W-1:0] sum_s_q, sum_u_q;
  logic signed [10:0] t1_q;
  tdvt_pkg::line_t    rowc_q;
  logic signed [48:0] prod_g_q;
  logic signed [32:0] diff0_q;
  logic signed [33:0] diff_q;
  logic signed [50:0] prod_a_q;

  logic               out_valid_q;
  logic [7:0]         out_t1_q, out_t2_q;
  logic [1:0]         out_verg_q;
  logic               out_expl_q;
  logic signed [31:0] out_val_q;

  // memory port
  logic                        mem_re, mem_we;
  logic [tdvt_pkg::ADDR_W-1:0] mem_raddr, mem_waddr;
  tdvt_pkg::line_t             mem_wdata, rd_line;

  // control
  logic fin, do_fin, slot_free, in_acc;
  logic upd_cur, upd_expl, expl_val;
  logic [7:0]         res_t1, res_t2;
  logic [1:0]         res_verg;
  logic signed [31:0] res_val;

  // datapath helpers
  logic [tdvt_pkg::ROW_W-1:0] i_row, up_row, dn_row, row_new, cur_row;
  logic [tdvt_pkg::COL_W-1:0] j_col, up_col, dn_col, cur_col;
  logic signed [tdvt_pkg::SUM_W-1:0] rd_sum;
  logic up_win, dn_win, explore_hit;
  logic signed [10:0] t1_nx, t1_lo, t1_hi, t1_cl, t2_nx, t2_cl, t1_ex;
  logic [tdvt_pkg::ROW_W-1:0] rrow_cl;
  logic [tdvt_pkg::COL_W-1:0] rcol_cl;
  logic signed [31:0] v_cur, next_val;
  logic signed [35:0] nv;
  logic signed [31:0] nv_sat;

  function automatic logic [tdvt_pkg::ROW_W-1:0] row_of(logic [7:0] t1, logic [7:0] base);
    logic signed [9:0] r;
    r = $signed({2'b0, t1}) - $signed({2'b0, base});
    if (r < 10'sd0) begin
      row_of = '0;
    end else if (r > $signed(10'(tdvt_pkg::ROWS - 1))) begin
      row_of = tdvt_pkg::ROW_W'(tdvt_pkg::ROWS - 1);
    end else begin
      row_of = tdvt_pkg::ROW_W'(r);
    end
  endfunction

  function automatic logic [tdvt_pkg::COL_W-1:0] col_of(logic [7:0] t2);
    if (t2 > 8'(tdvt_pkg::COLS - 1)) begin
      col_of = tdvt_pkg::COL_W'(tdvt_pkg::COLS - 1);
    end else begin
      col_of = tdvt_pkg::COL_W'(t2);
    end
  endfunction

  tdvt_ram #(
    .DEPTH (tdvt_pkg::DEPTH),
    .WIDTH (tdvt_pkg::LINE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_line)
  );

  assign in_ready_o  = (state_q == tdvt_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign do_fin      = fin && slot_free;

  // index arithmetic
  assign i_row   = row_of(t1_in_q, base_row_q);
  assign j_col   = col_of(t2_in_q);
  assign up_row  = (i_row == tdvt_pkg::ROW_W'(tdvt_pkg::ROWS - 1)) ? i_row : i_row + 1'b1;
  assign dn_row  = (i_row == '0) ? i_row : i_row - 1'b1;
  assign up_col  = (j_col == tdvt_pkg::COL_W'(tdvt_pkg::COLS - 1)) ? j_col : j_col + 1'b1;
  assign dn_col  = (j_col == '0) ? j_col : j_col - 1'b1;
  assign cur_row = row_of(cur_t1_q, base_row_q);
  assign cur_col = col_of(cur_t2_q);

  // greedy compare: stay on ties
  assign rd_sum = tdvt_pkg::line_sum(rd_line);
  assign up_win = (sum_u_q > rd_sum) && (sum_u_q > sum_s_q);
  assign dn_win = (sum_u_q < rd_sum) && (rd_sum > sum_s_q);

  assign t1_lo = $signed({3'b0, base_row_q});
  assign t1_hi = t1_lo + $signed(11'(tdvt_pkg::ROWS - 1));
  assign t1_nx = $signed({3'b0, t1_in_q}) + (up_win ? 11'sd1 : 11'sd0)
                 - (dn_win ? 11'sd1 : 11'sd0);
  assign t1_cl = (t1_nx < t1_lo) ? t1_lo : ((t1_nx > t1_hi) ? t1_hi : t1_nx);
  assign row_new = tdvt_pkg::ROW_W'(t1_cl - t1_lo);

  assign t2_nx = $signed({3'b0, t2_in_q}) + (up_win ? 11'sd1 : 11'sd0)
                 - (dn_win ? 11'sd1 : 11'sd0);
  assign t2_cl = (t2_nx < 11'sd0) ? 11'sd0 :
                 ((t2_nx > $signed(11'(tdvt_pkg::COLS - 1))) ?
                  $signed(11'(tdvt_pkg::COLS - 1)) : t2_nx);

  // explore jump
  assign explore_hit = {1'b0, rexp_q} < explore_prob_q;
  assign rrow_cl = (9'(rrow_q) > 9'(tdvt_pkg::ROWS - 1)) ?
                   tdvt_pkg::ROW_W'(tdvt_pkg::ROWS - 1) : tdvt_pkg::ROW_W'(rrow_q);
  assign rcol_cl = (9'(rcol_q) > 9'(tdvt_pkg::COLS - 1)) ?
                   tdvt_pkg::COL_W'(tdvt_pkg::COLS - 1) : tdvt_pkg::COL_W'(rcol_q);
  assign t1_ex   = t1_lo + $signed(11'(rrow_cl));

  // update arithmetic
  assign v_cur    = tdvt_pkg::lane_get(rowc_q, cur_verg_q);
  assign next_val = tdvt_pkg::lane_get(rd_line, verg_in_q);
  assign nv       = 36'(v_cur) + 36'($signed(prod_a_q[50:16]));
  assign nv_sat   = (nv[35:31] == 5'b00000 || nv[35:31] == 5'b11111) ? nv[31:0] :
                    (nv[35] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = clear_cnt_q;
    mem_wdata = {tdvt_pkg::VERG{tdvt_pkg::INIT_VALUE}};
    fin       = 1'b0;
    upd_cur   = 1'b0;
    upd_expl  = 1'b0;
    expl_val  = 1'b0;
    res_t1    = cur_t1_q;
    res_t2    = cur_t2_q;
    res_verg  = cur_verg_q;
    res_val   = '0;
    unique case (state_q)
      tdvt_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (clear_cnt_q == tdvt_pkg::ADDR_W'(tdvt_pkg::DEPTH - 1)) begin
          state_d = tdvt_pkg::S_IDLE;
        end
      end
      tdvt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = tdvt_pkg::S_DISP;
        end
      end
      tdvt_pkg::S_DISP: begin
        unique case (op_q)
          tdvt_pkg::OP_DRAW: begin
            if (explore_hit) begin
              fin      = 1'b1;
              upd_expl = 1'b1;
              expl_val = 1'b1;
              res_t1   = (t1_ex > 11'sd255) ? 8'hff : t1_ex[7:0];
              res_t2   = 8'(rcol_cl);
              res_verg = verg_in_q;
              if (slot_free) begin
                state_d = tdvt_pkg::S_IDLE;
              end
            end else begin
              state_d = tdvt_pkg::S_D_RS;
            end
          end
          tdvt_pkg::OP_UPDATE: begin
            state_d = tdvt_pkg::S_U_RC;
          end
          tdvt_pkg::OP_SET: begin
            fin      = 1'b1;
            upd_cur  = 1'b1;
            res_t1   = t1_in_q;
            res_t2   = t2_in_q;
            res_verg = verg_in_q;
            if (slot_free) begin
              state_d = tdvt_pkg::S_IDLE;
            end
          end
          tdvt_pkg::OP_NONE: begin
            fin = 1'b1;
            if (slot_free) begin
              state_d = tdvt_pkg::S_IDLE;
            end
          end
        endcase
      end
      tdvt_pkg::S_D_RS: begin
        mem_re    = 1'b1;
        mem_raddr = {i_row, j_col};
        state_d   = tdvt_pkg::S_D_RU;
      end
      tdvt_pkg::S_D_RU: begin
        mem_re    = 1'b1;
        mem_raddr = {up_row, j_col};
        state_d   = tdvt_pkg::S_D_RD;
      end
      tdvt_pkg::S_D_RD: begin
        mem_re    = 1'b1;
        mem_raddr = {dn_row, j_col};
        state_d   = tdvt_pkg::S_D_T1;
      end
      tdvt_pkg::S_D_T1: begin
        state_d = tdvt_pkg::S_D_CS;
      end
      tdvt_pkg::S_D_CS: begin
        mem_re    = 1'b1;
        mem_raddr = {row_i_q, j_col};
        state_d   = tdvt_pkg::S_D_CU;
      end
      tdvt_pkg::S_D_CU: begin
        mem_re    = 1'b1;
        mem_raddr = {row_i_q, up_col};
        state_d   = tdvt_pkg::S_D_CD;
      end
      tdvt_pkg::S_D_CD: begin
        mem_re    = 1'b1;
        mem_raddr = {row_i_q, dn_col};
        state_d   = tdvt_pkg::S_D_T2;
      end
      tdvt_pkg::S_D_T2: begin
        fin      = 1'b1;
        upd_expl = 1'b1;
        res_t1   = (t1_q > 11'sd255) ? 8'hff : t1_q[7:0];
        res_t2   = t2_cl[7:0];
        res_verg = verg_in_q;
        if (slot_free) begin
          state_d = tdvt_pkg::S_IDLE;
        end
      end
      tdvt_pkg::S_U_RC: begin
        mem_re    = 1'b1;
        mem_raddr = {cur_row, cur_col};
        state_d   = tdvt_pkg::S_U_RN;
      end
      tdvt_pkg::S_U_RN: begin
        mem_re    = 1'b1;
        mem_raddr = {i_row, j_col};
        state_d   = tdvt_pkg::S_U_M1;
      end
      tdvt_pkg::S_U_M1: begin
        state_d = tdvt_pkg::S_U_M2;
      end
      tdvt_pkg::S_U_M2: begin
        state_d = tdvt_pkg::S_U_M3;
      end
      tdvt_pkg::S_U_M3: begin
        state_d = tdvt_pkg::S_U_WB;
      end
      tdvt_pkg::S_U_WB: begin
        fin       = 1'b1;
        upd_cur   = 1'b1;
        res_t1    = t1_in_q;
        res_t2    = t2_in_q;
        res_verg  = verg_in_q;
        res_val   = nv_sat;
        mem_waddr = {cur_row, cur_col};
        mem_wdata = tdvt_pkg::lane_set(rowc_q, cur_verg_q, nv_sat);
        if (slot_free) begin
          mem_we  = 1'b1;
          state_d = tdvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tdvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdvt_pkg::S_CLEAR;
      clear_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == tdvt_pkg::S_CLEAR) begin
        clear_cnt_q <= clear_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_row_q     <= 8'd0;
      explore_prob_q <= 17'd6554;
      learn_rate_q   <= 16'd6554;
      discount_q     <= 16'd58982;
    end else if (cfg_valid_i) begin
      unique case (tdvt_pkg::cfg_idx_e'(cfg_index_i))
        tdvt_pkg::CFG_BASE_ROW:     base_row_q     <= cfg_data_i[7:0];
        tdvt_pkg::CFG_EXPLORE_PROB: explore_prob_q <= cfg_data_i;
        tdvt_pkg::CFG_LEARN_RATE:   learn_rate_q   <= cfg_data_i[15:0];
        tdvt_pkg::CFG_DISCOUNT:     discount_q     <= cfg_data_i[15:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_t1_q   <= '0;
      cur_t2_q   <= '0;
      cur_verg_q <= '0;
      explore_q  <= 1'b0;
    end else if (do_fin) begin
      if (upd_cur) begin
        cur_t1_q   <= t1_in_q;
        cur_t2_q   <= t2_in_q;
        cur_verg_q <= verg_in_q;
      end
      if (upd_expl) begin
        explore_q <= expl_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_fin) begin
      out_t1_q   <= res_t1;
      out_t2_q   <= res_t2;
      out_verg_q <= res_verg;
      out_expl_q <= upd_expl ? expl_val : explore_q;
      out_val_q  <= res_val;
    end
  end

  // hold the beat for the whole item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= tdvt_pkg::op_e'(op_i);
      t1_in_q   <= thres1_i;
      t2_in_q   <= thres2_i;
      verg_in_q <= vergence_i;
      reward_q  <= reward_i;
      rexp_q    <= rand_explore_i;
      rrow_q    <= rand_row_i;
      rcol_q    <= rand_col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tdvt_pkg::S_D_RU || state_q == tdvt_pkg::S_D_CU) begin
      sum_s_q <= rd_sum;
    end
    if (state_q == tdvt_pkg::S_D_RD || state_q == tdvt_pkg::S_D_CD) begin
      sum_u_q <= rd_sum;
    end
    if (state_q == tdvt_pkg::S_D_T1) begin
      t1_q    <= t1_cl;
      row_i_q <= row_new;
    end
    if (state_q == tdvt_pkg::S_U_RN) begin
      rowc_q <= rd_line;
    end
    if (state_q == tdvt_pkg::S_U_M1) begin
      prod_g_q <= 49'($signed({1'b0, discount_q}) * next_val);
      diff0_q  <= 33'(reward_q) - 33'(v_cur);
    end
    if (state_q == tdvt_pkg::S_U_M2) begin
      // drop the discounted term after an exploring draw
      diff_q <= 34'(diff0_q) + (explore_q ? 34'sd0 : 34'($signed(prod_g_q[48:16])));
    end
    if (state_q == tdvt_pkg::S_U_M3) begin
      prod_a_q <= 51'($signed({1'b0, learn_rate_q}) * diff_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_thres1_o   = out_t1_q;
  assign out_thres2_o   = out_t2_q;
  assign out_vergence_o = out_verg_q;
  assign explored_o     = out_expl_q;
  assign value_out_o    = out_val_q;

endmodule

@@ rtl/tdvt_ram.sv @@
module tdvt_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/tdvt_checker.sv @@
module tdvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_thres1_o,
  input logic [7:0]  out_thres2_o,
  input logic [31:0] value_out_o
);

  // one item at a time: the engine is busy right after a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // a result only comes out of a busy engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without an item in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_thres1_o)
      && $stable(out_thres2_o) && $stable(value_out_o))
    else $error("stalled result beat changed");

endmodule

bind td_value_table_greedy_agent_top tdvt_checker u_tdvt_checker (.*);

@@ tb/sv/tb_td_value_table_greedy_agent_top.sv @@
module tb_td_value_table_greedy_agent_top;

  typedef struct packed {
    tdvt_pkg::op_e      op;
    logic [7:0]         thres1;
    logic [7:0]         thres2;
    logic [1:0]         vergence;
    logic signed [31:0] reward;
    logic [15:0]        rand_explore;
    logic [5:0]         rand_row;
    logic [4:0]         rand_col;
  } agent_cmd_t;

  typedef struct packed {
    logic [7:0]         thres1;
    logic [7:0]         thres2;
    logic [1:0]         vergence;
    logic               explored;
    logic signed [31:0] value;
  } agent_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  agent_cmd_t  drv_cmd = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_thres1, out_thres2;
  logic [1:0]  out_vergence;
  logic        explored;
  logic signed [31:0] value_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  tdvt_pkg::cfg_idx_e cfg_index = tdvt_pkg::CFG_BASE_ROW;
  logic [16:0] cfg_data = '0;

  td_value_table_greedy_agent_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (drv_cmd.op),
    .thres1_i       (drv_cmd.thres1),
    .thres2_i       (drv_cmd.thres2),
    .vergence_i     (drv_cmd.vergence),
    .reward_i       (drv_cmd.reward),
    .rand_explore_i (drv_cmd.rand_explore),
    .rand_row_i     (drv_cmd.rand_row),
    .rand_col_i     (drv_cmd.rand_col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_thres1_o   (out_thres1),
    .out_thres2_o   (out_thres2),
    .out_vergence_o (out_vergence),
    .explored_o     (explored),
    .value_out_o    (value_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predicted agent state
  int          value_mem [tdvt_pkg::ROWS*tdvt_pkg::COLS*tdvt_pkg::VERG];
  logic        explore_q;
  logic [7:0]  cur_t1_q, cur_t2_q;
  logic [1:0]  cur_verg_q;
  logic [7:0]  base_row_q;
  logic [16:0] explore_prob_q;
  logic [15:0] learn_rate_q, discount_q;

  agent_cmd_t  cmd_q [$];
  agent_res_t  agent_res_q [$];
  int          n_errors = 0;
  int          gap_max = 18;
  int          stall_max = 18;

  function automatic int row_idx(logic [7:0] t1);
    int r;
    r = int'(t1) - int'(base_row_q);
    if (r < 0) r = 0;
    if (r > tdvt_pkg::ROWS - 1) r = tdvt_pkg::ROWS - 1;
    return r;
  endfunction

  function automatic int col_idx(logic [7:0] t2);
    return (t2 > tdvt_pkg::COLS - 1) ? tdvt_pkg::COLS - 1 : int'(t2);
  endfunction

  function automatic int verg_idx(logic [1:0] v);
    return (v > tdvt_pkg::VERG - 1) ? tdvt_pkg::VERG - 1 : int'(v);
  endfunction

  function automatic longint vergence_total(int r, int c);
    longint s;
    s = 0;
    for (int v = 0; v < tdvt_pkg::VERG; v++) begin
      s += value_mem[(r*tdvt_pkg::COLS + c)*tdvt_pkg::VERG + v];
    end
    return s;
  endfunction

  function automatic logic [7:0] sat8(int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  task automatic predict_step(agent_cmd_t c);
    agent_res_t r;
    int t1, t2, i, j, up, dn, ci, ni;
    longint qs, qu, qd, v, diff, nv;
    r = '0;
    if (c.op == tdvt_pkg::OP_DRAW) begin
      t1 = int'(c.thres1);
      t2 = int'(c.thres2);
      explore_q = {1'b0, c.rand_explore} < explore_prob_q;
      if (explore_q) begin
        t1 = int'(base_row_q) + ((c.rand_row > tdvt_pkg::ROWS - 1) ?
                                 tdvt_pkg::ROWS - 1 : int'(c.rand_row));
        t2 = (c.rand_col > tdvt_pkg::COLS - 1) ? tdvt_pkg::COLS - 1 : int'(c.rand_col);
      end else begin
        i = row_idx(c.thres1);
        j = col_idx(c.thres2);
        up = (i + 1 > tdvt_pkg::ROWS - 1) ? tdvt_pkg::ROWS - 1 : i + 1;
        dn = (i - 1 < 0) ? 0 : i - 1;
        qs = vergence_total(i, j);
        qu = vergence_total(up, j);
        qd = vergence_total(dn, j);
        if (qu > qd && qu > qs) t1++;
        if (qu < qd && qd > qs) t1--;
        if (t1 < int'(base_row_q)) t1 = int'(base_row_q);
        if (t1 > int'(base_row_q) + tdvt_pkg::ROWS - 1) begin
          t1 = int'(base_row_q) + tdvt_pkg::ROWS - 1;
        end
        i = t1 - int'(base_row_q);
        up = (j + 1 > tdvt_pkg::COLS - 1) ? tdvt_pkg::COLS - 1 : j + 1;
        dn = (j - 1 < 0) ? 0 : j - 1;
        qs = vergence_total(i, j);
        qu = vergence_total(i, up);
        qd = vergence_total(i, dn);
        if (qu > qd && qu > qs) t2++;
        if (qu < qd && qd > qs) t2--;
      end
      if (t2 < 0) t2 = 0;
      if (t2 > tdvt_pkg::COLS - 1) t2 = tdvt_pkg::COLS - 1;
      r.thres1 = sat8(t1);
      r.thres2 = sat8(t2);
      r.vergence = c.vergence;
      r.explored = explore_q;
      r.value = '0;
    end else begin
      if (c.op == tdvt_pkg::OP_UPDATE) begin
        ci = (row_idx(cur_t1_q)*tdvt_pkg::COLS + col_idx(cur_t2_q))*tdvt_pkg::VERG
             + verg_idx(cur_verg_q);
        ni = (row_idx(c.thres1)*tdvt_pkg::COLS + col_idx(c.thres2))*tdvt_pkg::VERG
             + verg_idx(c.vergence);
        v = value_mem[ci];
        diff = longint'(c.reward) - v;
        if (!explore_q) diff += (longint'(discount_q) * longint'(value_mem[ni])) >>> 16;
        nv = v + ((longint'(learn_rate_q) * diff) >>> 16);
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        value_mem[ci] = int'(nv);
        r.value = 32'(nv);
      end
      if (c.op == tdvt_pkg::OP_UPDATE || c.op == tdvt_pkg::OP_SET) begin
        cur_t1_q = c.thres1;
        cur_t2_q = c.thres2;
        cur_verg_q = c.vergence;
      end
      r.thres1 = cur_t1_q;
      r.thres2 = cur_t2_q;
      r.vergence = cur_verg_q;
      r.explored = explore_q;
    end
    agent_res_q.push_back(r);
  endtask

  // driver: one beat from the command queue, random gap after each accept
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) predict_step(drv_cmd);
      if (!in_valid || in_ready) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          drv_cmd <= cmd_q.pop_front();
          in_valid <= 1'b1;
          gap_cnt <= $urandom_range(0, gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat, stall ready at random
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    agent_res_t e;
    int n;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (agent_res_q.size() == 0) begin
          $error("result beat with no expectation");
          n_errors++;
        end else begin
          e = agent_res_q.pop_front();
          if (out_thres1 !== e.thres1) begin
            $error("out_thres1 exp %0d got %0d", e.thres1, out_thres1); n_errors++;
          end
          if (out_thres2 !== e.thres2) begin
            $error("out_thres2 exp %0d got %0d", e.thres2, out_thres2); n_errors++;
          end
          if (out_vergence !== e.vergence) begin
            $error("out_vergence exp %0d got %0d", e.vergence, out_vergence); n_errors++;
          end
          if (explored !== e.explored) begin
            $error("explored exp %0d got %0d", e.explored, explored); n_errors++;
          end
          if (value_out !== e.value) begin
            $error("value_out exp %0d got %0d", e.value, value_out); n_errors++;
          end
        end
        n = $urandom_range(0, stall_max);
        stall_cnt <= n;
        out_ready <= (n == 0);
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready <= (stall_cnt == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(tdvt_pkg::cfg_idx_e idx, logic [16:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tdvt_pkg::CFG_BASE_ROW:     base_row_q = data[7:0];
      tdvt_pkg::CFG_EXPLORE_PROB: explore_prob_q = data;
      tdvt_pkg::CFG_LEARN_RATE:   learn_rate_q = data[15:0];
      default:                    discount_q = data[15:0];
    endcase
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || agent_res_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic agent_cmd_t rand_cmd();
    agent_cmd_t c;
    int k;
    c.reward = $urandom;
    c.rand_explore = $urandom;
    c.rand_row = $urandom;
    c.rand_col = $urandom;
    k = $urandom_range(0, 99);
    c.op = (k < 45) ? tdvt_pkg::OP_DRAW : (k < 85) ? tdvt_pkg::OP_UPDATE :
           (k < 96) ? tdvt_pkg::OP_SET : tdvt_pkg::OP_NONE;
    // keep most states inside the table so the greedy step sees learned values
    if ($urandom_range(0, 9) == 0) begin
      c.thres1 = $urandom;
      c.thres2 = $urandom;
    end else begin
      c.thres1 = sat8(int'(base_row_q) + $urandom_range(0, 70) - 3);
      c.thres2 = $urandom_range(0, 8);
    end
    c.vergence = $urandom;
    if ($urandom_range(0, 3) != 0) c.reward = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    return c;
  endfunction

  function automatic agent_cmd_t mk(tdvt_pkg::op_e op, logic [7:0] t1, logic [7:0] t2,
                                    logic [1:0] vg, logic [31:0] rw, logic [15:0] rx,
                                    logic [5:0] rr, logic [4:0] rc);
    agent_cmd_t c;
    c = '{op, t1, t2, vg, rw, rx, rr, rc};
    return c;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < tdvt_pkg::ROWS*tdvt_pkg::COLS*tdvt_pkg::VERG; k++) begin
      value_mem[k] = 32'sd6553600;
    end
    explore_q = 1'b0;
    cur_t1_q = '0; cur_t2_q = '0; cur_verg_q = '0;
    base_row_q = '0; explore_prob_q = 17'd6554;
    learn_rate_q = 16'd6554; discount_q = 16'd58982;

    // directed: every op, ties, table edges, explore edges, reward extremes
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd0, 8'd0, 2'd0, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd10, 8'd5, 2'd3, 32'd0, 16'd0, 6'd63, 5'd31));
    cmd_q.push_back(mk(tdvt_pkg::OP_SET, 8'd5, 8'd3, 2'd1, 32'd0, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd5, 8'd3, 2'd1, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_UPDATE, 8'd6, 8'd3, 2'd1, 32'h7FFFFFFF, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_UPDATE, 8'd5, 8'd3, 2'd1, 32'h7FFFFFFF, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd5, 8'd3, 2'd1, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_UPDATE, 8'd5, 8'd4, 2'd2, 32'h80000000, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd6, 8'd4, 2'd2, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd255, 8'd255, 2'd3, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd63, 8'd31, 2'd0, 32'd0, 16'hFFFF, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_NONE, 8'hAA, 8'h55, 2'd2, 32'hFFFFFFFF, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd1, 8'd1, 2'd1, 32'd0, 16'd6553, 6'd33, 5'd17));
    cmd_q.push_back(mk(tdvt_pkg::OP_UPDATE, 8'd0, 8'd0, 2'd0, 32'h00010000, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_DRAW, 8'd0, 8'd0, 2'd0, 32'd0, 16'd6554, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_SET, 8'd255, 8'd255, 2'd3, 32'd0, 16'd0, 6'd0, 5'd0));
    cmd_q.push_back(mk(tdvt_pkg::OP_UPDATE, 8'd0, 8'd31, 2'd3, 32'hFFFF0000, 16'd0, 6'd0, 5'd0));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(tdvt_pkg::CFG_LEARN_RATE, 17'd65535);
          cfg_write(tdvt_pkg::CFG_DISCOUNT, 17'd65535);
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd0);
        end
        1: begin
          cfg_write(tdvt_pkg::CFG_BASE_ROW, 17'd255);
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd65536);
        end
        2: begin
          cfg_write(tdvt_pkg::CFG_BASE_ROW, 17'd200);
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd16384);
          cfg_write(tdvt_pkg::CFG_LEARN_RATE, 17'd0);
          cfg_write(tdvt_pkg::CFG_DISCOUNT, 17'd0);
        end
        3: begin
          cfg_write(tdvt_pkg::CFG_BASE_ROW, 17'd40);
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd3000);
          cfg_write(tdvt_pkg::CFG_LEARN_RATE, 17'd32768);
          cfg_write(tdvt_pkg::CFG_DISCOUNT, 17'd49152);
        end
        4: begin
          cfg_write(tdvt_pkg::CFG_BASE_ROW, 17'd0);
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd65535);
          cfg_write(tdvt_pkg::CFG_LEARN_RATE, 17'd20000);
        end
        default: begin
          cfg_write(tdvt_pkg::CFG_EXPLORE_PROB, 17'd1);
          cfg_write(tdvt_pkg::CFG_LEARN_RATE, 17'd65535);
          cfg_write(tdvt_pkg::CFG_DISCOUNT, 17'd65535);
        end
      endcase
      for (int n = 0; n < 200; n++) cmd_q.push_back(rand_cmd());
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("[td_value_table_greedy_agent_top] OK");
    end else begin
      $display("[td_value_table_greedy_agent_top] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[td_value_table_greedy_agent_top] ERROR");
    $finish;
  end

endmodule

@@ td_value_table_greedy_agent_top.f @@
rtl/tdvt_pkg.sv
rtl/tdvt_ram.sv
rtl/td_value_table_greedy_agent_top.sv
rtl/tdvt_checker.sv
tb/sv/tb_td_value_table_greedy_agent_top.sv
